// ----- rtl/core/lbc_pkg.sv -----
// Shared types, constants and address mapping for the bank conflict counter.
`default_nettype none

package lbc_pkg;

  // Tile layout constants
  localparam int ROW_LENGTH  = 32;
  localparam int PACK_WIDTH  = 8;
  localparam int LAYERS      = 2;
  localparam int BANKS       = 32;

  // Field widths
  localparam int ROW_W       = 6;
  localparam int COL_W       = 5;
  localparam int SLOT_W      = 10;
  localparam int BANK_W      = $clog2(BANKS);
  localparam int GROUP_W     = 5;
  localparam int TOTAL_W     = 32;

  // Per-group slot store
  localparam int STORE_DEPTH = 32;
  localparam int STORE_IW    = $clog2(STORE_DEPTH);

  localparam logic [GROUP_W-1:0] GROUP_MAX = {GROUP_W{1'b1}};
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

  // One mapped access on its way to the conflict stage
  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic              last;
    logic              start;
  } lbc_req_t;

  // Element (row, column) to 4-byte slot, plain or XOR-swizzled layout
  function automatic logic [SLOT_W-1:0] slot_of(input logic [ROW_W-1:0] row,
                                                input logic [COL_W-1:0] column,
                                                input logic             swz);
    logic [31:0] m;
    logic [31:0] k;
    logic [31:0] d0;
    logic [31:0] d1;
    logic [31:0] off;
    m = 32'(row);
    k = 32'(column);
    if (swz) begin
      d0  = 32'((k / PACK_WIDTH) * LAYERS + (m % LAYERS));
      d1  = 32'(m / LAYERS) ^ d0;
      off = 32'(d0 * PACK_WIDTH + d1 * (ROW_LENGTH * LAYERS) + (k % PACK_WIDTH));
    end else begin
      off = 32'(m * ROW_LENGTH + k);
    end
    // two bytes per element, four bytes per slot
    return off[SLOT_W:1];
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/lbc_ifs.sv -----
// Channel interfaces: access requests, results and the layout register write.
`default_nettype none

interface lbc_in_if;
  logic                      valid;
  logic                      ready;
  logic [lbc_pkg::ROW_W-1:0] row;
  logic [lbc_pkg::COL_W-1:0] column;
  logic                      last_in_group;
  logic                      start_run;
  modport source (output valid, row, column, last_in_group, start_run, input ready);
  modport sink   (input valid, row, column, last_in_group, start_run, output ready);
endinterface

interface lbc_out_if;
  logic                        valid;
  logic                        ready;
  logic [lbc_pkg::GROUP_W-1:0] group_conflicts;
  logic [lbc_pkg::TOTAL_W-1:0] run_conflicts;
  modport source (output valid, group_conflicts, run_conflicts, input ready);
  modport sink   (input valid, group_conflicts, run_conflicts, output ready);
endinterface

interface lbc_cfg_if;
  logic valid;
  logic ready;
  logic use_swizzle;
  modport source (output valid, use_swizzle, input ready);
  modport sink   (input valid, use_swizzle, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/lbc_addr_map.sv -----
// Input register stage: maps each accepted access to its slot.
`default_nettype none

module lbc_addr_map (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [lbc_pkg::ROW_W-1:0]    in_row,
  input  wire logic [lbc_pkg::COL_W-1:0]    in_column,
  input  wire logic                         in_last,
  input  wire logic                         in_start,
  input  wire logic                         use_swizzle,
  output logic                              req_valid,
  input  wire logic                         req_ready,
  output lbc_pkg::lbc_req_t                 req
);

  logic              valid_r;
  lbc_pkg::lbc_req_t req_r;

  // Stage empties or drains into the conflict stage in the same cycle
  assign in_ready  = !valid_r || req_ready;
  assign req_valid = valid_r;
  assign req       = req_r;

  // Valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  // Mapped request payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_r.slot  <= lbc_pkg::slot_of(in_row, in_column, use_swizzle);
      req_r.last  <= in_last;
      req_r.start <= in_start;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/lbc_conflict_unit.sv -----
// Slot store, parallel bank match, group and running counters, result register.
`default_nettype none

module lbc_conflict_unit (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          req_valid,
  output logic                               req_ready,
  input  wire lbc_pkg::lbc_req_t             req,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [lbc_pkg::GROUP_W-1:0]        out_group,
  output logic [lbc_pkg::TOTAL_W-1:0]        out_total
);

  logic [lbc_pkg::SLOT_W-1:0]   seen_r [lbc_pkg::STORE_DEPTH];
  logic [lbc_pkg::STORE_DEPTH-1:0] slot_valid_r;
  logic [lbc_pkg::GROUP_W-1:0]  group_r;
  logic [lbc_pkg::GROUP_W-1:0]  group_nxt;
  logic [lbc_pkg::TOTAL_W-1:0]  total_r;
  logic [lbc_pkg::TOTAL_W-1:0]  total_base;
  logic [lbc_pkg::TOTAL_W:0]    total_sum;
  logic [lbc_pkg::TOTAL_W-1:0]  total_nxt;
  logic                         out_valid_r;
  logic [lbc_pkg::GROUP_W-1:0]  out_group_r;
  logic [lbc_pkg::TOTAL_W-1:0]  out_total_r;
  logic [lbc_pkg::BANK_W-1:0]   bank;
  logic [lbc_pkg::STORE_DEPTH-1:0] hit_vec;
  logic [lbc_pkg::STORE_DEPTH-1:0] bank_vec;
  logic                         found;
  logic                         bank_used;
  logic                         has_free;
  logic [lbc_pkg::STORE_IW-1:0] free_idx;
  logic                         fire;

  // A closing request needs room in the result register
  assign req_ready = !req.last || !out_valid_r || out_ready;
  assign fire      = req_valid && req_ready;

  assign out_valid = out_valid_r;
  assign out_group = out_group_r;
  assign out_total = out_total_r;

  assign bank = lbc_pkg::BANK_W'(req.slot % lbc_pkg::BANKS);

  // Parallel compare against every stored slot
  always_comb begin
    for (int i = 0; i < lbc_pkg::STORE_DEPTH; i++) begin
      hit_vec[i]  = slot_valid_r[i] && (seen_r[i] == req.slot);
      bank_vec[i] = slot_valid_r[i] && (seen_r[i] != req.slot) &&
                    (lbc_pkg::BANK_W'(seen_r[i] % lbc_pkg::BANKS) == bank);
    end
  end

  assign found     = |hit_vec;
  assign bank_used = |bank_vec;
  assign has_free  = !(&slot_valid_r);

  // Lowest free entry
  always_comb begin
    free_idx = '0;
    for (int i = lbc_pkg::STORE_DEPTH - 1; i >= 0; i--) begin
      if (!slot_valid_r[i]) free_idx = lbc_pkg::STORE_IW'(i);
    end
  end

  // Group count and saturating running total
  always_comb begin
    group_nxt = group_r;
    if (!found && bank_used && group_r != lbc_pkg::GROUP_MAX) begin
      group_nxt = group_r + 1'b1;
    end
    total_base = req.start ? '0 : total_r;
    total_sum  = {1'b0, total_base} + (lbc_pkg::TOTAL_W + 1)'(group_nxt);
    total_nxt  = total_sum[lbc_pkg::TOTAL_W] ? lbc_pkg::TOTAL_MAX
                                             : total_sum[lbc_pkg::TOTAL_W-1:0];
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_valid_r <= '0;
      group_r      <= '0;
      total_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (fire) begin
        if (req.last) begin
          slot_valid_r <= '0;
          group_r      <= '0;
          total_r      <= total_nxt;
        end else begin
          if (!found && has_free) slot_valid_r[free_idx] <= 1'b1;
          group_r <= group_nxt;
          total_r <= total_base;
        end
      end
      if (fire && req.last) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Slot store and result payload
  always_ff @(posedge clk) begin
    if (fire && !req.last && !found && has_free) begin
      seen_r[free_idx] <= req.slot;
    end
    if (fire && req.last) begin
      out_group_r <= group_nxt;
      out_total_r <= total_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/lds_bank_conflict_counter.sv -----
// Top level of the shared-memory bank conflict counter.
// Each request is one lane's 16-bit element access (row, column). It is mapped
// to a 4-byte slot, row-major or XOR-swizzled as selected by use_swizzle, and
// its bank is the slot modulo 32. Within a lane group every new slot whose bank
// already holds a different slot adds one conflict (saturating at 31);
// up to 32 distinct slots per group are remembered. The request flagged
// last_in_group produces one result: that group's conflicts and a running total
// saturating at 2^32-1; start_run clears the total first. Throughput is one
// request per cycle; a request passes the input register, then the store
// compare into the result register. A stalled result holds back only a
// group-closing request. Write use_swizzle only while idle.
`default_nettype none

module lds_bank_conflict_counter (
  input  wire logic  clk,
  input  wire logic  rst_n,
  lbc_in_if.sink     in_ch,
  lbc_out_if.source  out_ch,
  lbc_cfg_if.sink    cfg_ch
);

  logic              use_swizzle_r;
  logic              req_valid;
  logic              req_ready;
  lbc_pkg::lbc_req_t req;

  // Layout register
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      use_swizzle_r <= 1'b0;
    end else if (cfg_ch.valid) begin
      use_swizzle_r <= cfg_ch.use_swizzle;
    end
  end

  // Address mapping stage
  lbc_addr_map u_addr_map (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .in_row      (in_ch.row),
    .in_column   (in_ch.column),
    .in_last     (in_ch.last_in_group),
    .in_start    (in_ch.start_run),
    .use_swizzle (use_swizzle_r),
    .req_valid   (req_valid),
    .req_ready   (req_ready),
    .req         (req)
  );

  // Conflict stage
  lbc_conflict_unit u_conflict (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_group (out_ch.group_conflicts),
    .out_total (out_ch.run_conflicts)
  );

endmodule

`default_nettype wire

// ----- rtl/core/lbc_checker.sv -----
// Port-level checks for the bank conflict counter and their bind.
`default_nettype none

module lbc_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        in_ready,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic [lbc_pkg::GROUP_W-1:0] out_group,
  input wire logic [lbc_pkg::TOTAL_W-1:0] out_total
);

  // Reset leaves no result pending
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Requests are only held back by a stalled result
  a_ready_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid || out_ready) |-> in_ready)
    else $error("input stalled while result side is free");

  // A stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_group) && $stable(out_total)))
    else $error("stalled result changed");

  // Running total never falls below the group it includes
  a_total_covers_group: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_total >= lbc_pkg::TOTAL_W'(out_group)))
    else $error("total below group conflicts");

endmodule

bind lds_bank_conflict_counter lbc_checker u_lbc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_group (out_ch.group_conflicts),
  .out_total (out_ch.run_conflicts)
);

`default_nettype wire

// ----- tb/sv/lbc_conflict_checker.sv -----
// Passive checker: predicts per-group bank conflict tallies and compares results.
module lbc_conflict_checker
  import lbc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  lbc_in_if    in_mon,
  lbc_out_if   out_mon,
  lbc_cfg_if   cfg_mon,
  output int   fail_count,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int REPORT_MAX = 10;

  // One expected group result
  typedef struct packed {
    logic [GROUP_W-1:0] grp;
    logic [TOTAL_W-1:0] tot;
  } tally_t;

  tally_t             tally_q[$];
  logic               swz_mode;
  logic [SLOT_W-1:0]  slot_seen [STORE_DEPTH];
  bit                 slot_live [STORE_DEPTH];
  logic [GROUP_W-1:0] grp_cnt;
  logic [TOTAL_W-1:0] run_total;

  // Element (row, column) to 4-byte slot under the current layout
  function automatic logic [SLOT_W-1:0] map_slot(input logic [ROW_W-1:0] r,
                                                 input logic [COL_W-1:0] c,
                                                 input logic             swz);
    int unsigned rr;
    int unsigned cc;
    int unsigned d0;
    int unsigned d1;
    int unsigned offset;
    rr = 32'(r);
    cc = 32'(c);
    if (swz) begin
      d0     = (cc / PACK_WIDTH) * LAYERS + rr % LAYERS;
      d1     = (rr / LAYERS) ^ d0;
      offset = d0 * PACK_WIDTH + d1 * ROW_LENGTH * LAYERS + cc % PACK_WIDTH;
    end else begin
      offset = rr * ROW_LENGTH + cc;
    end
    // 2-byte elements into 4-byte slots, slot number wraps at SLOT_W bits
    return SLOT_W'(offset >> 1);
  endfunction

  // Advance the group store by one lane access; queue a tally on the closing lane
  function automatic void tally_access(input logic [ROW_W-1:0] r,
                                       input logic [COL_W-1:0] c,
                                       input logic             last,
                                       input logic             start);
    logic [SLOT_W-1:0] slot;
    bit                hit;
    bit                bank_busy;
    int                free_ix;
    int                i;
    tally_t            t;
    if (start) run_total = '0;
    slot      = map_slot(r, c, swz_mode);
    hit       = 1'b0;
    bank_busy = 1'b0;
    free_ix   = -1;
    for (i = 0; i < STORE_DEPTH; i++) begin
      if (slot_live[i]) begin
        if (slot_seen[i] == slot) hit = 1'b1;
        else if (slot_seen[i][BANK_W-1:0] == slot[BANK_W-1:0]) bank_busy = 1'b1;
      end else if (free_ix < 0) begin
        free_ix = i;
      end
    end
    // new slot: maybe a conflict, stored only while the store has room
    if (!hit) begin
      if (bank_busy && grp_cnt != GROUP_MAX) grp_cnt++;
      if (free_ix >= 0) begin
        slot_seen[free_ix] = slot;
        slot_live[free_ix] = 1'b1;
      end
    end
    if (last) begin
      if (run_total > TOTAL_MAX - TOTAL_W'(grp_cnt)) run_total = TOTAL_MAX;
      else run_total = run_total + TOTAL_W'(grp_cnt);
      t.grp = grp_cnt;
      t.tot = run_total;
      tally_q.push_back(t);
      for (i = 0; i < STORE_DEPTH; i++) slot_live[i] = 1'b0;
      grp_cnt = '0;
    end
  endfunction

  function automatic void flag_mismatch(input string what);
    fail_count++;
    if (fail_count <= REPORT_MAX) $display("%s", what);
  endfunction

  // Results are compared before the same edge's request is predicted
  always @(posedge clk) begin
    tally_t want;
    int     i;
    if (!rst_n) begin
      swz_mode  = 1'b0;
      grp_cnt   = '0;
      run_total = '0;
      for (i = 0; i < STORE_DEPTH; i++) slot_live[i] = 1'b0;
      tally_q.delete();
    end else begin
      if ((out_mon.valid & out_mon.ready) === 1'b1) begin
        if (tally_q.size() == 0) begin
          flag_mismatch($sformatf("unexpected result: grp=%0d total=%0d",
                                  out_mon.group_conflicts, out_mon.run_conflicts));
        end else begin
          want = tally_q.pop_front();
          if (out_mon.group_conflicts !== want.grp ||
              out_mon.run_conflicts !== want.tot)
            flag_mismatch($sformatf({"result mismatch: expected grp=%0d total=%0d,",
                                     " got grp=%0d total=%0d"},
                                    want.grp, want.tot,
                                    out_mon.group_conflicts, out_mon.run_conflicts));
        end
      end
      if ((cfg_mon.valid & cfg_mon.ready) === 1'b1) swz_mode = cfg_mon.use_swizzle;
      if ((in_mon.valid & in_mon.ready) === 1'b1)
        tally_access(in_mon.row, in_mon.column, in_mon.last_in_group, in_mon.start_run);
    end
    pending = tally_q.size();
  end

endmodule

// ----- tb/sv/tb_top.sv -----
// Testbench top: clock, reset, access stimulus, result back-pressure and the verdict.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import lbc_pkg::*;

  localparam int IDLE_LIMIT    = 2000;
  localparam int HOLD_OFF      = 400;
  localparam int HOLD_AT       = 12;
  localparam int DRAIN_WAIT    = 4;
  localparam int PHASE_ITEMS   = 220;
  localparam int RANDOM_PHASES = 6;

  // Shapes of a random lane group
  typedef enum int {
    GRP_SCATTER,
    GRP_HAMMER,
    GRP_FILL,
    GRP_SHORT
  } group_kind_t;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;
  bit   send_burst;
  bit   take_burst;
  int   results_taken;

  lbc_in_if  access_ch ();
  lbc_out_if tally_ch ();
  lbc_cfg_if layout_ch ();

  lds_bank_conflict_counter DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (access_ch),
    .out_ch (tally_ch),
    .cfg_ch (layout_ch)
  );

  lbc_conflict_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (access_ch),
    .out_mon    (tally_ch),
    .cfg_mon    (layout_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Offer one access request after a random gap and hold it until taken
  task automatic send_access(input logic [ROW_W-1:0] r, input logic [COL_W-1:0] c,
                             input logic last, input logic start);
    int unsigned gap;
    if ($urandom_range(0, 63) == 0) send_burst = !send_burst;
    gap = send_burst ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      @(negedge clk);
      access_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    access_ch.valid         <= 1'b1;
    access_ch.row           <= r;
    access_ch.column        <= c;
    access_ch.last_in_group <= last;
    access_ch.start_run     <= start;
    do @(posedge clk); while ((access_ch.valid & access_ch.ready) !== 1'b1);
  endtask

  // Stop offering, wait for every expected tally, then let the pipe empty
  task automatic settle();
    @(negedge clk);
    access_ch.valid <= 1'b0;
    wait (pending == 0);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_layout(input logic swz);
    @(negedge clk);
    layout_ch.valid       <= 1'b1;
    layout_ch.use_swizzle <= swz;
    do @(posedge clk); while ((layout_ch.valid & layout_ch.ready) !== 1'b1);
    @(negedge clk);
    layout_ch.valid <= 1'b0;
  endtask

  // One well-formed lane group with random content, closed by last_in_group
  task automatic emit_group(output int lanes);
    group_kind_t      kind;
    int unsigned      pick;
    int unsigned      len;
    int unsigned      i;
    int unsigned      par;
    int unsigned      base_row;
    logic [COL_W-1:0] col_a;
    logic [COL_W-1:0] col_b;
    logic [ROW_W-1:0] r;
    logic [COL_W-1:0] c;
    logic             st;
    pick = $urandom_range(0, 9);
    if (pick < 4) kind = GRP_SCATTER;
    else if (pick < 7) kind = GRP_HAMMER;
    else if (pick < 9) kind = GRP_FILL;
    else kind = GRP_SHORT;
    case (kind)
      GRP_SCATTER: len = $urandom_range(1, 40);
      GRP_HAMMER:  len = $urandom_range(20, 70);
      GRP_FILL:    len = $urandom_range(33, 48);
      default:     len = $urandom_range(1, 3);
    endcase
    par      = $urandom_range(0, 1);
    base_row = $urandom_range(0, 62);
    col_a    = COL_W'($urandom_range(0, 31));
    col_b    = COL_W'($urandom_range(0, 31));
    for (i = 0; i < len; i++) begin
      if (kind == GRP_HAMMER) begin
        // same row parity and few columns: piles onto one or two banks
        r = ROW_W'(($urandom_range(0, 31) << 1) | par);
        c = $urandom_range(0, 1) ? col_a : col_b;
      end else if (kind == GRP_FILL && i < STORE_DEPTH) begin
        // 32 distinct slots fill the store, the tail then overflows it
        r = ROW_W'(base_row + i / 16);
        c = COL_W'((i % 16) * 2);
      end else begin
        r = ROW_W'($urandom_range(0, 63));
        c = COL_W'($urandom_range(0, 31));
      end
      if (kind == GRP_SHORT) st = 1'($urandom_range(0, 1));
      else if (i == 0) st = ($urandom_range(0, 5) == 0);
      else st = ($urandom_range(0, 39) == 0);
      send_access(r, c, i == len - 1, st);
    end
    lanes = len;
  endtask

  // Result side: random stall after each result, one long hold-off
  initial begin : receiver
    int unsigned stall;
    forever begin
      do @(posedge clk); while ((tally_ch.valid & tally_ch.ready) !== 1'b1);
      results_taken++;
      if ($urandom_range(0, 15) == 0) take_burst = !take_burst;
      if (results_taken == HOLD_AT) stall = HOLD_OFF;
      else if (take_burst) stall = 0;
      else stall = $urandom_range(0, 8);
      if (stall > 0) begin
        @(negedge clk);
        tally_ch.ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
        @(negedge clk);
        tally_ch.ready <= 1'b1;
      end
    end
  end

  // Ends the run when no request moves on any channel for too long
  initial begin : watchdog
    int idle;
    idle = 0;
    do begin
      @(posedge clk);
      if ((access_ch.valid & access_ch.ready) === 1'b1 ||
          (tally_ch.valid & tally_ch.ready) === 1'b1 ||
          (layout_ch.valid & layout_ch.ready) === 1'b1)
        idle = 0;
      else
        idle++;
    end while (idle < IDLE_LIMIT);
    $display("tb_top NOT OK");
    $finish;
  end

  initial begin : stimulus
    int sent;
    int lanes;
    int p;
    rst_n                   = 1'b0;
    access_ch.valid         = 1'b0;
    access_ch.row           = '0;
    access_ch.column        = '0;
    access_ch.last_in_group = 1'b0;
    access_ch.start_run     = 1'b0;
    tally_ch.ready          = 1'b1;
    layout_ch.valid         = 1'b0;
    layout_ch.use_swizzle   = 1'b0;
    send_burst              = 1'b0;
    take_burst              = 1'b0;
    results_taken           = 0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // Row-major layout from reset: start with last on a one-lane group
    send_access(6'd0, 5'd0, 1'b1, 1'b1);
    // top corner, a bank repeat, a same-slot repeat
    send_access(6'd63, 5'd31, 1'b0, 1'b0);
    send_access(6'd61, 5'd31, 1'b0, 1'b0);
    send_access(6'd63, 5'd30, 1'b0, 1'b0);
    send_access(6'd0, 5'd31, 1'b1, 1'b0);
    // conflicts in one bank, total restarted on the closing lane
    send_access(6'd1, 5'd0, 1'b0, 1'b0);
    send_access(6'd1, 5'd1, 1'b0, 1'b0);
    send_access(6'd3, 5'd0, 1'b0, 1'b0);
    send_access(6'd5, 5'd0, 1'b1, 1'b1);
    send_access(6'd63, 5'd31, 1'b1, 1'b1);
    settle();

    // Swizzled layout corners
    write_layout(1'b1);
    send_access(6'd0, 5'd0, 1'b0, 1'b0);
    send_access(6'd63, 5'd31, 1'b0, 1'b0);
    send_access(6'd62, 5'd24, 1'b0, 1'b0);
    send_access(6'd1, 5'd7, 1'b0, 1'b0);
    send_access(6'd2, 5'd8, 1'b1, 1'b0);
    send_access(6'd63, 5'd31, 1'b1, 1'b0);

    // Random groups, layout flipped between phases
    for (p = 0; p < RANDOM_PHASES; p++) begin
      settle();
      write_layout(p % 2 == 1);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        emit_group(lanes);
        sent += lanes;
      end
    end
    settle();

    if (fail_count == 0)
      $display("tb_top OK");
    else
      $display("tb_top NOT OK");
    $finish;
  end

endmodule
